>>> sv/nup_pkg.sv
// shared types, constants and helpers for the n-up tile placer
`timescale 1ns / 1ps
`default_nettype none
package nup_pkg;

  localparam int SIZE_W      = 22;
  localparam int SCALE_W     = 24;
  localparam int AXIS_W      = 5;
  localparam int SLOT_W      = 9;
  localparam int PROD_W      = SIZE_W + SCALE_W;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = SIZE_W;
  localparam int DIV_W       = SIZE_W;
  localparam int DIV_BITS_W  = SCALE_W;
  localparam int DIV_CNT_W   = 5;

  localparam logic [AXIS_W-1:0] MAX_AXIS = 5'd16;

  localparam logic [CFG_INDEX_W-1:0] REG_SHEET_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SHEET_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COLUMNS      = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ROWS         = 2'd3;

  localparam logic [SIZE_W-1:0]  RESET_SHEET_WIDTH  = 22'd156672;
  localparam logic [SIZE_W-1:0]  RESET_SHEET_HEIGHT = 22'd202752;
  localparam logic [AXIS_W-1:0]  RESET_COLUMNS      = 5'd2;
  localparam logic [AXIS_W-1:0]  RESET_ROWS         = 5'd2;
  localparam logic [SIZE_W-1:0]  RESET_CELL_WIDTH   = 22'd78336;
  localparam logic [SIZE_W-1:0]  RESET_CELL_HEIGHT  = 22'd101376;
  localparam logic [SCALE_W-1:0] SCALE_MAX          = 24'hFFFFFF;

  localparam logic [DIV_CNT_W-1:0] CELL_STEPS  = 5'd22;
  localparam logic [DIV_CNT_W-1:0] SLOT_STEPS  = 5'd9;
  localparam logic [DIV_CNT_W-1:0] SCALE_STEPS = 5'd24;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CW,
    S_CH,
    S_SLOT,
    S_XS,
    S_YS,
    S_MP,
    S_MX,
    S_MY,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                  start;
    logic [DIV_W-1:0]      rem_init;
    logic [DIV_BITS_W-1:0] bits;
    logic [DIV_CNT_W-1:0]  count;
    logic [DIV_W-1:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [DIV_BITS_W-1:0] quotient;
    logic [DIV_W-1:0]      remainder;
  } div_rsp_t;

  function automatic logic [AXIS_W-1:0] clamp_axis(input logic [AXIS_W-1:0] n);
    logic [AXIS_W-1:0] r;
    r = n;
    if (n == '0) begin
      r = 5'd1;
    end else if (n > MAX_AXIS) begin
      r = MAX_AXIS;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> sv/nup_if.sv
// page and placement channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface nup_in_if;
  import nup_pkg::*;
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] page_width;
  logic [SIZE_W-1:0] page_height;

  modport source (output valid, output page_width, output page_height, input ready);
  modport sink (input valid, input page_width, input page_height, output ready);
endinterface

interface nup_out_if;
  import nup_pkg::*;
  logic               valid;
  logic               ready;
  logic [SIZE_W-1:0]  origin_x;
  logic [SIZE_W-1:0]  origin_y;
  logic [SCALE_W-1:0] scale;
  logic               sheet_start;

  modport source (output valid, output origin_x, output origin_y, output scale,
                  output sheet_start, input ready);
  modport sink (input valid, input origin_x, input origin_y, input scale,
                input sheet_start, output ready);
endinterface
`default_nettype wire

>>> sv/n_up_tile_placer_top.sv
// n-up tile placer: cell sizing, scale division and placement sequencer
// a page transfer runs a scale division for each axis whose scale does not
//   saturate; the shared divider gives one quotient bit a cycle
// one page at a time: a new page is taken only after the last one is placed
// a register write starts a pass on the divider that sizes the cells
// reset: synchronous, restores the register defaults, slot 0 and the default cells
`timescale 1ns / 1ps
`default_nettype none
module n_up_tile_placer_top import nup_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  nup_in_if.sink                      page,
  nup_out_if.source                   place
);

  state_t state, state_next;
  logic   launch, launch_next;
  logic   dirty;

  logic [SIZE_W-1:0] sheet_width, sheet_height;
  logic [AXIS_W-1:0] columns, rows;
  logic [SIZE_W-1:0] cell_width, cell_height;
  logic [SLOT_W-1:0] slot;
  logic [AXIS_W-1:0] col, rowidx;

  logic [SIZE_W-1:0]  pw, ph;
  logic [3:0]         col_i, row_i;
  logic               start_flag;
  logic [SCALE_W-1:0] xs, ys;
  logic [PROD_W-1:0]  prod;
  logic [SIZE_W-2:0]  slack;
  logic [SIZE_W-1:0]  ox;

  logic               out_valid;
  logic [SIZE_W-1:0]  out_x, out_y;
  logic [SCALE_W-1:0] out_scale;
  logic               out_start;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [AXIS_W-1:0]   cols_c, rws_c;
  logic [2*AXIS_W-1:0] per_sheet;
  logic                wrap;
  logic [SLOT_W-1:0]   slot_eff;
  logic [AXIS_W-1:0]   col_eff, rowidx_eff, col_inc;
  logic                col_roll;
  logic                accept, out_free, div_ok;
  logic                sat_x, sat_y, x_center;
  logic [SCALE_W-1:0]  sc;
  logic [SIZE_W-1:0]   page_sel, cell_sel;
  logic [PROD_W-17:0]  placed;
  logic [SIZE_W-1:0]   mul_a;
  logic [SCALE_W-1:0]  mul_b;
  logic [PROD_W-1:0]   mul_p;

  nup_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign cols_c     = clamp_axis(columns);
  assign rws_c      = clamp_axis(rows);
  assign per_sheet  = (2*AXIS_W)'(cols_c) * (2*AXIS_W)'(rws_c);
  assign wrap       = (2*AXIS_W)'(slot) >= per_sheet;
  assign slot_eff   = wrap ? '0 : slot;
  assign col_eff    = wrap ? '0 : col;
  assign rowidx_eff = wrap ? '0 : rowidx;
  assign col_inc    = col_eff + 1'b1;
  assign col_roll   = col_inc == cols_c;

  assign page.ready = (state == S_IDLE) && !dirty && !cfg_we;
  assign accept     = page.valid && page.ready;
  assign out_free   = !out_valid || place.ready;
  assign div_ok     = div_rsp.done && !launch;

  assign sat_x    = {8'b0, cell_width[SIZE_W-1:8]} >= pw;
  assign sat_y    = {8'b0, cell_height[SIZE_W-1:8]} >= ph;
  assign x_center = xs > ys;
  assign sc       = (xs < ys) ? xs : ys;
  assign page_sel = x_center ? pw : ph;
  assign cell_sel = x_center ? cell_width : cell_height;
  assign placed   = prod[PROD_W-1:16];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (dirty && !cfg_we) begin
          state_next = S_CW;
        end else if (accept) begin
          state_next = S_XS;
        end
      end
      S_CW: begin
        if (cfg_we) state_next = S_IDLE;
        else if (div_ok) state_next = S_CH;
      end
      S_CH: begin
        if (cfg_we) state_next = S_IDLE;
        else if (div_ok) state_next = S_SLOT;
      end
      S_SLOT: begin
        if (cfg_we || div_ok) state_next = S_IDLE;
      end
      S_XS: begin
        if (sat_x || div_ok) state_next = S_YS;
      end
      S_YS: begin
        if (sat_y || div_ok) state_next = S_MP;
      end
      S_MP: state_next = S_MX;
      S_MX: state_next = S_MY;
      S_MY: state_next = S_DONE;
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    launch_next = (state_next == S_CW || state_next == S_CH || state_next == S_SLOT ||
                   state_next == S_XS || state_next == S_YS) && (state_next != state);
  end

  // divider and multiplier operands
  always_comb begin
    div_req = '0;
    mul_a   = '0;
    mul_b   = '0;
    unique case (state)
      S_CW: begin
        div_req.start   = launch;
        div_req.bits    = {sheet_width, 2'b0};
        div_req.count   = CELL_STEPS;
        div_req.divisor = DIV_W'(cols_c);
      end
      S_CH: begin
        div_req.start   = launch;
        div_req.bits    = {sheet_height, 2'b0};
        div_req.count   = CELL_STEPS;
        div_req.divisor = DIV_W'(rws_c);
      end
      S_SLOT: begin
        div_req.start   = launch;
        div_req.bits    = {slot, 15'b0};
        div_req.count   = SLOT_STEPS;
        div_req.divisor = DIV_W'(cols_c);
      end
      S_XS: begin
        div_req.start    = launch && !sat_x;
        div_req.rem_init = {8'b0, cell_width[SIZE_W-1:8]};
        div_req.bits     = {cell_width[7:0], 16'b0};
        div_req.count    = SCALE_STEPS;
        div_req.divisor  = pw;
      end
      S_YS: begin
        div_req.start    = launch && !sat_y;
        div_req.rem_init = {8'b0, cell_height[SIZE_W-1:8]};
        div_req.bits     = {cell_height[7:0], 16'b0};
        div_req.count    = SCALE_STEPS;
        div_req.divisor  = ph;
      end
      S_MP: begin
        mul_a = page_sel;
        mul_b = sc;
      end
      S_MX: begin
        mul_a = cell_width;
        mul_b = SCALE_W'(col_i);
      end
      S_MY: begin
        mul_a = cell_height;
        mul_b = SCALE_W'(row_i);
      end
      S_IDLE, S_DONE: begin
        mul_a = '0;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      launch       <= 1'b0;
      dirty        <= 1'b0;
      sheet_width  <= RESET_SHEET_WIDTH;
      sheet_height <= RESET_SHEET_HEIGHT;
      columns      <= RESET_COLUMNS;
      rows         <= RESET_ROWS;
      cell_width   <= RESET_CELL_WIDTH;
      cell_height  <= RESET_CELL_HEIGHT;
      slot         <= '0;
      col          <= '0;
      rowidx       <= '0;
      out_valid    <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= launch_next;
      if (state == S_CW && div_ok) cell_width <= div_rsp.quotient[SIZE_W-1:0];
      if (state == S_CH && div_ok) cell_height <= div_rsp.quotient[SIZE_W-1:0];
      if (state == S_SLOT && div_ok) begin
        rowidx <= div_rsp.quotient[AXIS_W-1:0];
        col    <= div_rsp.remainder[AXIS_W-1:0];
        dirty  <= 1'b0;
      end
      if (accept) begin
        slot   <= slot_eff + 1'b1;
        col    <= col_roll ? '0 : col_inc;
        rowidx <= col_roll ? rowidx_eff + 1'b1 : rowidx_eff;
      end
      if (cfg_we) begin
        dirty <= 1'b1;
        unique case (cfg_index)
          REG_SHEET_WIDTH:  sheet_width  <= cfg_data;
          REG_SHEET_HEIGHT: sheet_height <= cfg_data;
          REG_COLUMNS:      columns      <= cfg_data[AXIS_W-1:0];
          REG_ROWS:         rows         <= cfg_data[AXIS_W-1:0];
          default:          dirty        <= 1'b1;
        endcase
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (place.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state != S_DONE) prod <= mul_p;
    if (accept) begin
      pw         <= page.page_width;
      ph         <= page.page_height;
      col_i      <= col_eff[3:0];
      row_i      <= 4'(rws_c - 5'd1 - rowidx_eff);
      start_flag <= slot_eff == '0;
    end
    if (state == S_XS) begin
      if (sat_x) xs <= SCALE_MAX;
      else if (div_ok) xs <= div_rsp.quotient;
    end
    if (state == S_YS) begin
      if (sat_y) ys <= SCALE_MAX;
      else if (div_ok) ys <= div_rsp.quotient;
    end
    if (state == S_MX) begin
      if (placed >= (PROD_W-16)'(cell_sel)) slack <= '0;
      else slack <= 21'((cell_sel - placed[SIZE_W-1:0]) >> 1);
    end
    if (state == S_MY) ox <= prod[SIZE_W-1:0];
    if (state == S_DONE && out_free) begin
      out_x     <= ox + (x_center ? SIZE_W'(slack) : '0);
      out_y     <= prod[SIZE_W-1:0] + (x_center ? '0 : SIZE_W'(slack));
      out_scale <= sc;
      out_start <= start_flag;
    end
  end

  assign place.valid       = out_valid;
  assign place.origin_x    = out_x;
  assign place.origin_y    = out_y;
  assign place.scale       = out_scale;
  assign place.sheet_start = out_start;

  // a transfer in closes the input until the page is placed
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    accept |=> !page.ready)
    else $error("page ready right after a transfer");

  // the slot column stays inside the grid
  a_col_in_grid: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && !dirty) |-> (wrap || (col < cols_c)))
    else $error("slot column outside the grid");

  // divider is never running during the multiply and output steps
  a_div_quiet: assert property (@(posedge clk) disable iff (rst)
    div_rsp.busy |-> !(state == S_MP || state == S_MX || state == S_MY || state == S_DONE))
    else $error("divider busy outside a division step");

endmodule
`default_nettype wire

>>> sv/nup_div.sv
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module nup_div import nup_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  div_req_t  req,
  output div_rsp_t  rsp
);

  logic                  busy;
  logic                  done;
  logic [DIV_CNT_W-1:0]  cnt;
  logic [DIV_W-1:0]      rem;
  logic [DIV_BITS_W-1:0] bits;
  logic [DIV_BITS_W-1:0] quo;
  logic [DIV_W-1:0]      divisor;

  logic [DIV_W:0] trial;
  logic [DIV_W:0] diff;
  logic           ge;

  assign trial = {rem, bits[DIV_BITS_W-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.count;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= req.rem_init;
      bits    <= req.bits;
      divisor <= req.divisor;
      quo     <= '0;
    end else if (busy) begin
      rem  <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      bits <= {bits[DIV_BITS_W-2:0], 1'b0};
      quo  <= {quo[DIV_BITS_W-2:0], ge};
    end
  end

  assign rsp.busy      = busy;
  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule
`default_nettype wire
